FILE: hdl/etok_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// etok_pkg
// Shared types and constants for the elevation text tokenizer.
// ----------------------------------------------------------------------------
package etok_pkg;

   localparam int HEIGHT_BITS   = 16;
   localparam int IPART_BITS    = HEIGHT_BITS + 1;
   localparam int PROD_BITS     = IPART_BITS + 3;
   localparam int CSR_ADDR_BITS = 3;
   localparam int CSR_DATA_BITS = 32;

   localparam logic [HEIGHT_BITS-1:0] HEIGHT_MAX  = {HEIGHT_BITS{1'b1}};
   localparam logic [IPART_BITS-1:0]  IPART_SAT   = {1'b1, {HEIGHT_BITS{1'b0}}};
   localparam logic [HEIGHT_BITS-1:0] SHELF_RESET = HEIGHT_BITS'(200);

   localparam logic [7:0] CHAR_MINUS = 8'h2D;
   localparam logic [7:0] CHAR_POINT = 8'h2E;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_NINE  = 8'h39;

   // register index, taken from paddr above the byte offset
   localparam logic REG_SHELF_OFFSET = 1'b0;

   typedef enum logic [2:0] {
      PH_START  = 3'd0,
      PH_SIGNED = 3'd1,
      PH_INT    = 3'd2,
      PH_POINT  = 3'd3,
      PH_FRAC   = 3'd4,
      PH_STOP   = 3'd5
   } phase_type;

   typedef struct packed {
      logic                  active;
      phase_type             phase;
      logic                  negative;
      logic                  seen_digit;
      logic [IPART_BITS-1:0] ipart;
      logic                  round_up;
   } token_type;

   typedef struct packed {
      logic      fire;
      logic      eot;
      token_type tok;
   } scan_type;

endpackage

FILE: hdl/etok_scan.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// etok_scan
// Token state register and the per-character prefix reader.
// ----------------------------------------------------------------------------
module etok_scan (
   input  logic              clock,
   input  logic              reset,
   input  logic              step,
   input  logic [7:0]        char_code,
   input  logic              last_char,
   output etok_pkg::scan_type scan
);
   import etok_pkg::*;

   token_type             tok_ff;
   token_type             tok_in;
   token_type             fed;
   phase_type             phase_next;
   logic                  dig;
   logic                  used;
   logic [3:0]            dval;
   logic [PROD_BITS-1:0]  prod;
   logic [IPART_BITS-1:0] ipart_dig;

   assign dig  = (char_code >= CHAR_ZERO) && (char_code <= CHAR_NINE);
   assign used = dig || (char_code == CHAR_MINUS) || (char_code == CHAR_POINT);
   assign dval = char_code[3:0];

   // accumulate one digit, saturate one above the height range
   assign prod = ({3'b000, tok_ff.ipart} << 3) + ({3'b000, tok_ff.ipart} << 1)
               + {{(PROD_BITS-4){1'b0}}, dval};
   assign ipart_dig = (prod > {3'b000, IPART_SAT}) ? IPART_SAT : prod[IPART_BITS-1:0];

   // next phase
   always_comb begin
      phase_next = tok_ff.phase;
      unique case (tok_ff.phase)
         PH_START: begin
            if (char_code == CHAR_MINUS) phase_next = PH_SIGNED;
            else if (dig)                phase_next = PH_INT;
            else                         phase_next = PH_POINT;
         end
         PH_SIGNED: begin
            if (dig)                          phase_next = PH_INT;
            else if (char_code == CHAR_POINT) phase_next = PH_POINT;
            else                              phase_next = PH_STOP;
         end
         PH_INT: begin
            if (dig)                          phase_next = PH_INT;
            else if (char_code == CHAR_POINT) phase_next = PH_POINT;
            else                              phase_next = PH_STOP;
         end
         PH_POINT: begin
            phase_next = dig ? PH_FRAC : PH_STOP;
         end
         PH_FRAC: begin
            phase_next = dig ? PH_FRAC : PH_STOP;
         end
         default: begin
            phase_next = PH_STOP;
         end
      endcase
   end

   // token fields after taking this character
   always_comb begin
      fed        = tok_ff;
      fed.active = 1'b1;
      fed.phase  = phase_next;
      unique case (tok_ff.phase)
         PH_START: begin
            if (char_code == CHAR_MINUS) begin
               fed.negative = 1'b1;
            end else if (dig) begin
               fed.ipart      = ipart_dig;
               fed.seen_digit = 1'b1;
            end
         end
         PH_SIGNED, PH_INT: begin
            if (dig) begin
               fed.ipart      = ipart_dig;
               fed.seen_digit = 1'b1;
            end
         end
         PH_POINT: begin
            if (dig) begin
               fed.seen_digit = 1'b1;
               fed.round_up   = (dval >= 4'd5);
            end
         end
         default: begin
         end
      endcase
   end

   // emit on a flushed token; drop the token after any emit or separator
   always_comb begin
      scan.fire = used ? last_char : tok_ff.active;
      scan.eot  = last_char;
      scan.tok  = used ? fed : tok_ff;
      tok_in    = (scan.fire || !used) ? '0 : fed;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tok_ff <= '0;
      end else if (step) begin
         tok_ff <= tok_in;
      end
   end

endmodule

FILE: hdl/etok_value.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// etok_value
// Clamp, round and offset a finished token into an elevation and status.
// ----------------------------------------------------------------------------
module etok_value (
   input  etok_pkg::token_type                  tok,
   input  logic [etok_pkg::HEIGHT_BITS-1:0]     shelf_offset,
   output logic [etok_pkg::HEIGHT_BITS-1:0]     elevation,
   output logic                                 status
);
   import etok_pkg::*;

   logic [HEIGHT_BITS-1:0] base;
   logic [HEIGHT_BITS:0]   sum;

   always_comb begin
      if (tok.ipart >= {1'b0, HEIGHT_MAX}) begin
         base = HEIGHT_MAX;
      end else begin
         base = tok.ipart[HEIGHT_BITS-1:0] + {{(HEIGHT_BITS-1){1'b0}}, tok.round_up};
      end
      sum = {1'b0, base} + {1'b0, shelf_offset};

      elevation = '0;
      status    = 1'b0;
      if (!tok.seen_digit) begin
         status = 1'b1;
      end else if (!tok.negative && (base != '0)) begin
         elevation = sum[HEIGHT_BITS] ? HEIGHT_MAX : sum[HEIGHT_BITS-1:0];
      end
   end

endmodule

FILE: hdl/elevation_text_tokenizer_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// elevation_text_tokenizer_core
// Turns a stream of ASCII elevation text into clamped 16-bit elevations.
// ----------------------------------------------------------------------------
// Usage:
//   req_ channel: one character word per accepted beat (req_valid high,
//   req_stall low), with req_last_char marking the final byte of the text.
//   rsp_ channel: one elevation word per finished token, with status set
//   for a token that holds no digit and end_of_text set on the flush that
//   the last character causes.
//   csr_ port: APB-style; shelf_offset at byte address 0, reset value 200.
//   Write it only while the block is idle.
// Timing:
//   A character is captured in an input register, then the token reader
//   and the value formatter run combinationally into the output register.
//   rsp_valid rises when the output register loads the word of the character
//   that finishes a token; one character is taken every cycle unless stalled.
// Reset and stall:
//   Synchronous reset clears the token and both valid flags and restores
//   the offset to 200.
//   While rsp_stall holds a result, the input register holds too and
//   req_stall rises once it is full; no word is dropped or repeated.
// ----------------------------------------------------------------------------
module elevation_text_tokenizer_core (
   input  logic                                  clock,
   input  logic                                  reset,
   // character channel
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic [7:0]                            req_char_code,
   input  logic                                  req_last_char,
   // elevation channel
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic [etok_pkg::HEIGHT_BITS-1:0]      rsp_elevation,
   output logic                                  rsp_status,
   output logic                                  rsp_end_of_text,
   // configuration port
   input  logic                                  csr_psel,
   input  logic                                  csr_penable,
   input  logic                                  csr_pwrite,
   input  logic [etok_pkg::CSR_ADDR_BITS-1:0]    csr_paddr,
   input  logic [etok_pkg::CSR_DATA_BITS-1:0]    csr_pwdata,
   output logic [etok_pkg::CSR_DATA_BITS-1:0]    csr_prdata,
   output logic                                  csr_pready
);
   import etok_pkg::*;

   // input register
   logic       in_valid_ff;
   logic [7:0] in_char_ff;
   logic       in_last_ff;

   // output register
   logic                   out_valid_ff;
   logic [HEIGHT_BITS-1:0] out_elev_ff;
   logic                   out_status_ff;
   logic                   out_eot_ff;

   logic [HEIGHT_BITS-1:0] shelf_offset_ff;

   logic                   advance;
   logic                   step;
   scan_type               scan;
   logic [HEIGHT_BITS-1:0] elev_in;
   logic                   status_in;
   logic                   reg_sel;

   // the output register can take a new word when empty or being drained
   assign advance   = !out_valid_ff || !rsp_stall;
   assign step      = in_valid_ff && advance;
   assign req_stall = in_valid_ff && !advance;

   // configuration: register index sits above the byte offset
   assign reg_sel    = csr_paddr[CSR_ADDR_BITS-1];
   assign csr_pready = 1'b1;
   assign csr_prdata = (reg_sel == REG_SHELF_OFFSET)
                     ? {{(CSR_DATA_BITS-HEIGHT_BITS){1'b0}}, shelf_offset_ff}
                     : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         shelf_offset_ff <= SHELF_RESET;
      end else if (csr_psel && csr_penable && csr_pwrite && csr_pready
                   && (reg_sel == REG_SHELF_OFFSET)) begin
         shelf_offset_ff <= csr_pwdata[HEIGHT_BITS-1:0];
      end
   end

   // capture a character whenever the input register is free
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_char_ff <= req_char_code;
         in_last_ff <= req_last_char;
      end
   end

   etok_scan u_scan (
      .clock     (clock),
      .reset     (reset),
      .step      (step),
      .char_code (in_char_ff),
      .last_char (in_last_ff),
      .scan      (scan)
   );

   etok_value u_value (
      .tok          (scan.tok),
      .shelf_offset (shelf_offset_ff),
      .elevation    (elev_in),
      .status       (status_in)
   );

   // advance the output register; a character that ends no token leaves it empty
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= step && scan.fire;
      end
   end

   always_ff @(posedge clock) begin
      if (step && scan.fire) begin
         out_elev_ff   <= elev_in;
         out_status_ff <= status_in;
         out_eot_ff    <= scan.eot;
      end
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_elevation   = out_elev_ff;
   assign rsp_status      = out_status_ff;
   assign rsp_end_of_text = out_eot_ff;

endmodule

FILE: test/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the elevation text tokenizer core.
// ----------------------------------------------------------------------------
// Feeds character words through the req_ channel. A directed table goes
// first, then three random phases of token-shaped text. Each phase uses its
// own shelf offset and its own idling pattern. A local scanner tracks the
// token state and predicts every elevation word. Each accepted rsp_ word is
// compared with the oldest prediction. The offset register is written and
// read back over the csr_ port only while the core is quiet.
// ----------------------------------------------------------------------------
module tb;
   import etok_pkg::*;

   localparam logic STATUS_OK        = 1'b0;
   localparam logic STATUS_MALFORMED = 1'b1;

   localparam logic [CSR_ADDR_BITS-1:0] SHELF_ADDR = {REG_SHELF_OFFSET, 2'b00};
   localparam int CYCLE_LIMIT = 400000;
   localparam int QUIET_CYCLES = 4;

   typedef struct packed {
      logic [HEIGHT_BITS-1:0] elevation;
      logic                   status;
      logic                   end_of_text;
   } elev_word_type;

   typedef struct packed {
      logic [7:0]    ch;
      logic          last;
      logic          known;
      elev_word_type want;
   } text_row_type;

   // ------------------------------------------------------------------
   // Clock, DUT inputs (all known from time zero) and outputs
   // ------------------------------------------------------------------
   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                     req_valid = 1'b0;
   logic                     req_stall;
   logic [7:0]               req_char_code = '0;
   logic                     req_last_char = 1'b0;
   logic                     rsp_valid;
   logic                     rsp_stall = 1'b0;
   logic [HEIGHT_BITS-1:0]   rsp_elevation;
   logic                     rsp_status;
   logic                     rsp_end_of_text;
   logic                     csr_psel = 1'b0;
   logic                     csr_penable = 1'b0;
   logic                     csr_pwrite = 1'b0;
   logic [CSR_ADDR_BITS-1:0] csr_paddr = '0;
   logic [CSR_DATA_BITS-1:0] csr_pwdata = '0;
   logic [CSR_DATA_BITS-1:0] csr_prdata;
   logic                     csr_pready;

   // typed-in expectation that travels with the word on the req_ channel
   logic          row_known = 1'b0;
   elev_word_type row_want = '0;

   int send_gap_pct = 37;
   int rsp_stall_pct = 73;
   int error_count = 0;
   int cycle_count = 0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   elevation_text_tokenizer_core dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_char_code   (req_char_code),
      .req_last_char   (req_last_char),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_elevation   (rsp_elevation),
      .rsp_status      (rsp_status),
      .rsp_end_of_text (rsp_end_of_text),
      .csr_psel        (csr_psel),
      .csr_penable     (csr_penable),
      .csr_pwrite      (csr_pwrite),
      .csr_paddr       (csr_paddr),
      .csr_pwdata      (csr_pwdata),
      .csr_prdata      (csr_prdata),
      .csr_pready      (csr_pready)
   );

   // ------------------------------------------------------------------
   // Token scanner: a local copy of the token state and the offset
   // ------------------------------------------------------------------
   logic                   scan_open;
   phase_type              scan_phase;
   logic                   scan_neg;
   logic                   scan_digit;
   int unsigned            scan_ipart;
   logic                   scan_round;
   logic [HEIGHT_BITS-1:0] shelf_now;

   elev_word_type elev_due_q[$];

   function automatic void clear_scan();
      scan_open  = 1'b0;
      scan_phase = PH_START;
      scan_neg   = 1'b0;
      scan_digit = 1'b0;
      scan_ipart = 0;
      scan_round = 1'b0;
   endfunction

   // integer digits saturate one above the height range, so nothing wraps
   function automatic void add_digit(input int unsigned d);
      scan_ipart = scan_ipart * 10 + d;
      if (scan_ipart > IPART_SAT) scan_ipart = IPART_SAT;
      scan_digit = 1'b1;
   endfunction

   function automatic elev_word_type close_token(input logic eot);
      elev_word_type w;
      int unsigned   v;
      v = 0;
      w.status = STATUS_OK;
      if (!scan_digit) begin
         w.status = STATUS_MALFORMED;
      end else if (!scan_neg) begin
         // clamp first, round half away from zero, then add the shelf
         v = (scan_ipart >= HEIGHT_MAX) ? HEIGHT_MAX : scan_ipart + scan_round;
         if (v > 0) begin
            v = v + shelf_now;
            if (v > HEIGHT_MAX) v = HEIGHT_MAX;
         end
      end
      w.elevation   = v[HEIGHT_BITS-1:0];
      w.end_of_text = eot;
      clear_scan();
      return w;
   endfunction

   // Advance the scanner by one character; return 1 when a word is due.
   function automatic bit tokenize_char(input logic [7:0] c, input logic last,
                                        output elev_word_type w);
      logic        is_dig;
      int unsigned d;
      is_dig = (c >= CHAR_ZERO) && (c <= CHAR_NINE);
      d = is_dig ? int'(c - CHAR_ZERO) : 0;
      w = '0;
      if (is_dig || c == CHAR_MINUS || c == CHAR_POINT) begin
         scan_open = 1'b1;
         case (scan_phase)
            PH_START: begin
               if (c == CHAR_MINUS) begin
                  scan_neg   = 1'b1;
                  scan_phase = PH_SIGNED;
               end else if (is_dig) begin
                  add_digit(d);
                  scan_phase = PH_INT;
               end else begin
                  scan_phase = PH_POINT;
               end
            end
            PH_SIGNED: begin
               if (is_dig) begin
                  add_digit(d);
                  scan_phase = PH_INT;
               end else if (c == CHAR_POINT) begin
                  scan_phase = PH_POINT;
               end else begin
                  scan_phase = PH_STOP;
               end
            end
            PH_INT: begin
               if (is_dig) add_digit(d);
               else if (c == CHAR_POINT) scan_phase = PH_POINT;
               else scan_phase = PH_STOP;
            end
            PH_POINT: begin
               // only the first fraction digit decides the rounding
               if (is_dig) begin
                  scan_digit = 1'b1;
                  scan_round = (d >= 5);
                  scan_phase = PH_FRAC;
               end else begin
                  scan_phase = PH_STOP;
               end
            end
            PH_FRAC: begin
               if (!is_dig) scan_phase = PH_STOP;
            end
            default: scan_phase = PH_STOP;
         endcase
         if (last) begin
            w = close_token(1'b1);
            return 1'b1;
         end
         return 1'b0;
      end
      // any other byte is a separator: close an open token, else drop it
      if (scan_open) begin
         w = close_token(last);
         return 1'b1;
      end
      clear_scan();
      return 1'b0;
   endfunction

   // ------------------------------------------------------------------
   // Watch both channels at the rising edge (pre-edge values only)
   // ------------------------------------------------------------------
   always @(posedge clock) begin : watch_words
      elev_word_type predicted;
      elev_word_type seen;
      elev_word_type due;
      bit            fired;
      if (reset) begin
         clear_scan();
         shelf_now = SHELF_RESET;
         elev_due_q.delete();
      end else begin
         if (req_valid && !req_stall) begin
            fired = tokenize_char(req_char_code, req_last_char, predicted);
            // a typed-in row overrides the scanner's word
            if (row_known) elev_due_q = {elev_due_q, row_want};
            else if (fired) elev_due_q = {elev_due_q, predicted};
         end
         if (rsp_valid && !rsp_stall) begin
            seen = '{rsp_elevation, rsp_status, rsp_end_of_text};
            if (elev_due_q.size() == 0) begin
               $display("%0t: unexpected word: elevation %0d status %0b eot %0b",
                        $time, seen.elevation, seen.status, seen.end_of_text);
               error_count++;
            end else begin
               due = elev_due_q.pop_front();
               if (seen !== due) begin
                  $display({"%0t: mismatch: expected elevation %0d status %0b eot %0b,",
                            " got elevation %0d status %0b eot %0b"}, $time,
                           due.elevation, due.status, due.end_of_text,
                           seen.elevation, seen.status, seen.end_of_text);
                  error_count++;
               end
            end
         end
      end
   end

   // receiver side: stall at random with the current pressure
   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < rsp_stall_pct);
   end

   // watchdog: end the run if the core locks up
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   // ------------------------------------------------------------------
   // Drivers
   // ------------------------------------------------------------------

   // Offer one character word, after a random gap, and hold it until taken.
   task automatic send_word(input logic [7:0] ch, input logic last,
                            input logic known, input elev_word_type want);
      int gap;
      gap = 0;
      while ($urandom_range(99) < send_gap_pct) gap++;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_char_code <= ch;
      req_last_char <= last;
      row_known     <= known;
      row_want      <= want;
      do @(posedge clock); while (!(req_valid && !req_stall));
   endtask

   // Drop valid, wait for every due word, then let the pipeline settle.
   task automatic drain_words();
      req_valid <= 1'b0;
      @(posedge clock);
      while (elev_due_q.size() != 0) @(posedge clock);
      repeat (QUIET_CYCLES) @(posedge clock);
   endtask

   // One APB transfer: setup cycle, then access until pready.
   task automatic csr_access(input logic wr, input logic [CSR_ADDR_BITS-1:0] addr,
                             input logic [CSR_DATA_BITS-1:0] wdata,
                             output logic [CSR_DATA_BITS-1:0] rdata);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= wr;
      csr_paddr   <= addr;
      csr_pwdata  <= wdata;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      rdata = csr_prdata;
      if (wr) shelf_now = wdata[HEIGHT_BITS-1:0];
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   task automatic check_shelf(input logic [HEIGHT_BITS-1:0] want);
      logic [CSR_DATA_BITS-1:0] rd;
      csr_access(1'b0, SHELF_ADDR, '0, rd);
      if (rd[HEIGHT_BITS-1:0] !== want) begin
         $display("%0t: shelf_offset readback: expected %0d, got %0d",
                  $time, want, rd[HEIGHT_BITS-1:0]);
         error_count++;
      end
   endtask

   // write, idle so the bus returns to rest, then read back
   task automatic set_shelf(input logic [HEIGHT_BITS-1:0] value);
      logic [CSR_DATA_BITS-1:0] rd;
      csr_access(1'b1, SHELF_ADDR, CSR_DATA_BITS'(value), rd);
      @(posedge clock);
      check_shelf(value);
   endtask

   // Random text: mostly number-shaped tokens with random content, the rest
   // loose runs of digits, signs and points. Each token ends on a separator
   // or on a last-character flag.
   task automatic send_random_text(input int n_items);
      logic [7:0] chars[$];
      logic [7:0] sep;
      string      digits;
      string      lexicon;
      int         sent;
      int         ending;
      lexicon = "0123456789-..";
      sent = 0;
      while (sent < n_items) begin
         chars.delete();
         digits = "";
         if ($urandom_range(99) < 75) begin
            if ($urandom_range(3) == 0) chars = {chars, CHAR_MINUS};
            case ($urandom_range(5))
               0:       digits = "";
               1, 2:    digits = $sformatf("%0d", $urandom_range(999));
               3:       digits = $sformatf("%0d", $urandom_range(65000, 70000));
               4:       digits = $sformatf("%0d", $urandom_range(9999999));
               default: digits = $sformatf("0%0d", $urandom_range(99));
            endcase
            for (int i = 0; i < digits.len(); i++) chars = {chars, digits[i]};
            if ($urandom_range(1) == 1) begin
               chars = {chars, CHAR_POINT};
               repeat ($urandom_range(3))
                  chars = {chars, 8'(CHAR_ZERO + 8'($urandom_range(9)))};
            end
         end else begin
            repeat ($urandom_range(1, 5)) chars = {chars, lexicon[$urandom_range(12)]};
         end
         ending = $urandom_range(9);
         foreach (chars[i]) begin
            send_word(chars[i], (ending == 0) && (i == chars.size() - 1), 1'b0, '0);
            sent++;
         end
         // a flag on the final character flushes the token by itself
         if (!(ending == 0 && chars.size() > 0)) begin
            do sep = 8'($urandom_range(255));
            while (sep inside {[CHAR_ZERO:CHAR_NINE], CHAR_MINUS, CHAR_POINT});
            send_word(sep, ending == 1, 1'b0, '0);
            sent++;
         end
      end
   endtask

   // ------------------------------------------------------------------
   // Directed text, shelf offset at its reset value of 200
   // ------------------------------------------------------------------
   text_row_type directed_text [26] = '{
      // plain integer closed by a NUL separator
      '{"5",   1'b0, 1'b0, '{16'd0,     STATUS_OK,        1'b0}},
      '{8'h00, 1'b0, 1'b1, '{16'd205,   STATUS_OK,        1'b0}},
      // double sign: the prefix stops before any digit
      '{"-",   1'b0, 1'b0, '{16'd0,     STATUS_OK,        1'b0}},
      '{"-",   1'b0, 1'b0, '{16'd0,     STATUS_OK,        1'b0}},
      '{"5",   1'b0, 1'b0, '{16'd0,     STATUS_OK,        1'b0}},
      '{" ",   1'b0, 1'b1, '{16'd0,     STATUS_MALFORMED, 1'b0}},
      // lone point flushed by its own last-character flag
      '{".",   1'b1, 1'b1, '{16'd0,     STATUS_MALFORMED, 1'b1}},
      // end of text with nothing pending emits no word
      '{" ",   1'b1, 1'b0, '{16'd0,     STATUS_OK,        1'b0}},
      // negative value clamps to zero and gets no shelf
      '{"-",   1'b0, 1'b0, '{16'd0,     STATUS_OK,        1'b0}},
      '{"3",   1'b1, 1'b1, '{16'd0,     STATUS_OK,        1'b1}},
      // huge value saturates, top-bit separator
      '{"9",   1'b0, 1'b0, '{16'd0,     STATUS_OK,        1'b0}},
      '{"9",   1'b0, 1'b0, '{16'd0,     STATUS_OK,        1'b0}},
      '{"9",   1'b0, 1'b0, '{16'd0,     STATUS_OK,        1'b0}},
      '{"9",   1'b0, 1'b0, '{16'd0,     STATUS_OK,        1'b0}},
      '{"9",   1'b0, 1'b0, '{16'd0,     STATUS_OK,        1'b0}},
      '{8'hFF, 1'b0, 1'b1, '{16'hFFFF,  STATUS_OK,        1'b0}},
      // half rounds away from zero
      '{"2",   1'b0, 1'b0, '{16'd0,     STATUS_OK,        1'b0}},
      '{".",   1'b0, 1'b0, '{16'd0,     STATUS_OK,        1'b0}},
      '{"5",   1'b0, 1'b0, '{16'd0,     STATUS_OK,        1'b0}},
      '{8'h7F, 1'b0, 1'b1, '{16'd203,   STATUS_OK,        1'b0}},
      // shelf pushes the sum past the top: saturate
      '{"6",   1'b0, 1'b0, '{16'd0,     STATUS_OK,        1'b0}},
      '{"5",   1'b0, 1'b0, '{16'd0,     STATUS_OK,        1'b0}},
      '{"4",   1'b0, 1'b0, '{16'd0,     STATUS_OK,        1'b0}},
      '{"0",   1'b0, 1'b0, '{16'd0,     STATUS_OK,        1'b0}},
      '{"0",   1'b0, 1'b0, '{16'd0,     STATUS_OK,        1'b0}},
      '{",",   1'b1, 1'b1, '{16'hFFFF,  STATUS_OK,        1'b1}}
   };

   // ------------------------------------------------------------------
   // Run sequence
   // ------------------------------------------------------------------
   initial begin
      // hold reset, then release it for good
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      check_shelf(SHELF_RESET);

      // sender idles lightly, receiver stalls heavily
      send_gap_pct  = 37;
      rsp_stall_pct = 73;
      foreach (directed_text[i]) begin
         send_word(directed_text[i].ch, directed_text[i].last,
                   directed_text[i].known, directed_text[i].want);
      end
      drain_words();

      // zero shelf: positive values pass through untouched
      set_shelf('0);
      send_random_text(350);
      drain_words();

      // full shelf: every positive value saturates; swap the pressure
      set_shelf(HEIGHT_MAX);
      send_gap_pct  = 73;
      rsp_stall_pct = 37;
      send_random_text(380);
      drain_words();

      // mid-range shelf at full rate on both sides
      set_shelf(HEIGHT_BITS'($urandom_range(1, 1000)));
      send_gap_pct  = 0;
      rsp_stall_pct = 0;
      send_random_text(400);
      drain_words();

      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
